// File: rtl/rgbhsl_pkg.sv
// Shared constants and types for the RGB to HSL converter.
// No dependencies; imported by rgb_to_hsl_core.
package rgbhsl_pkg;

  localparam int CHAN_W       = 8;   // one color channel
  localparam int FIELD_W      = 15;  // hue, saturation and luminance ports
  localparam int SUM_W        = 9;   // max + min, up to 510
  localparam int HNUM_W       = 17;  // hue numerator, up to 360 * 255
  localparam int SNUM_W       = 15;  // 100 * d, up to 25500
  localparam int ARITH_W      = 18;  // working width for the hue numerator
  localparam int HUE_INT_W    = 9;   // integer bits of hue, up to 360
  localparam int PCT_INT_W    = 7;   // integer bits of a percentage, up to 100

  localparam int HUE_FRAC_DEF = 6;
  localparam int PCT_FRAC_DEF = 8;

  localparam logic [SUM_W-1:0] SUM_HALF    = 9'd255;
  localparam logic [SUM_W-1:0] SUM_FULL    = 9'd510;
  localparam logic [SUM_W-1:0] LUM_DIVISOR = 9'd510;

  // luminance remainder term: halved product under 2^17, then divide by 255
  // as a multiply by ceil(2^26 / 255) and a shift, exact for that range
  localparam int                      LUM_HALF_W  = 2 * SUM_W - 1;
  localparam int                      LUM_RECIP_W = 19;
  localparam logic [LUM_RECIP_W-1:0]  LUM_RECIP   = 19'd263173;
  localparam int                      LUM_SHIFT   = 26;

  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [FIELD_W-1:0] field_t;

endpackage

// File: rtl/rgbhsl_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; instanced by rgb_to_hsl_core. Quotient must fit in QW bits.
module rgbhsl_div #(
  parameter int RW = 33,  // dividend width, at least DW + QW - 1
  parameter int DW = 9,   // divisor width
  parameter int QW = 15   // quotient width, one stage per bit
) (
  input  logic          clk,
  input  logic [RW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [RW-1:0] rem [QW];
  logic [DW-1:0] dsr [QW];
  logic [QW-1:0] qacc [QW+1];

  assign rem[0]  = num;
  assign dsr[0]  = den;
  assign qacc[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int SH = QW - 1 - k;
    logic [RW-1:0] trial;
    logic          ge;
    logic [QW-1:0] q_next;

    always_comb begin
      trial      = RW'(dsr[k]) << SH;
      ge         = (rem[k] >= trial);
      q_next     = qacc[k];
      q_next[SH] = ge;
    end

    always_ff @(posedge clk) begin
      qacc[k+1] <= q_next;
    end

    if (k < QW - 1) begin : g_carry
      // subtract the shifted divisor when it fits, else hold the remainder
      always_ff @(posedge clk) begin
        rem[k+1] <= ge ? (rem[k] - trial) : rem[k];
        dsr[k+1] <= dsr[k];
      end
    end
  end

  assign quo = qacc[QW];

endmodule

// File: rtl/rgb_to_hsl_core.sv
// RGB to HSL converter, top level: extremes, numerators, divider lanes.
// Depends on rgbhsl_pkg and rgbhsl_div.
//
// Usage
//   Request channel: drive red, green and blue and raise start. A request is
//   taken at every rising edge where start is high and busy is low. busy is
//   high only while rst is high, so outside reset a new pixel is taken every
//   clock.
//   Result channel: done is high for exactly one cycle per request, with hue,
//   saturation and luminance valid in that same cycle. Results leave in
//   request order. The receiver cannot stall the block, and the block never
//   needs it to: nothing inside waits on the result side.
//   Pipeline: capture, extremes and numerator stages, the divider stages and
//   the output register. The quotients are QW bits wide, where
//   QW = max(9 + HUE_FRAC_BITS, 7 + PERCENT_FRAC_BITS). The depth is set by
//   the restoring dividers for hue and saturation, which resolve one quotient
//   bit per register stage. Luminance divides by the constant 510 with a
//   reciprocal multiply and rides a delay line matched to the dividers.
//   Throughput: one pixel per clock outside reset.
//   Reset: synchronous rst clears every valid bit in the pipeline; requests
//   in flight are dropped and no done pulse follows for them.
//   Outputs: grey pixels give hue 0 and saturation 0. The exact quotients
//   never pass 360 degrees or 100 percent, so no clamp stage is needed;
//   each field keeps its low 15 bits.
module rgb_to_hsl_core #(
  parameter int HUE_FRAC_BITS     = rgbhsl_pkg::HUE_FRAC_DEF,
  parameter int PERCENT_FRAC_BITS = rgbhsl_pkg::PCT_FRAC_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rgbhsl_pkg::chan_t   red,
  input  rgbhsl_pkg::chan_t   green,
  input  rgbhsl_pkg::chan_t   blue,
  output logic                done,
  output rgbhsl_pkg::field_t  hue,
  output rgbhsl_pkg::field_t  saturation,
  output rgbhsl_pkg::field_t  luminance
);
  import rgbhsl_pkg::*;

  localparam int FRAC_MAX = (HUE_FRAC_BITS > PERCENT_FRAC_BITS) ?
                            HUE_FRAC_BITS : PERCENT_FRAC_BITS;
  localparam int QW = (HUE_INT_W + HUE_FRAC_BITS > PCT_INT_W + PERCENT_FRAC_BITS) ?
                      HUE_INT_W + HUE_FRAC_BITS : PCT_INT_W + PERCENT_FRAC_BITS;
  localparam int NUM_W = HNUM_W + FRAC_MAX;
  localparam int RW = (SUM_W + QW > NUM_W) ? SUM_W + QW : NUM_W;
  localparam int LAT = QW + 4;
  // split 100 * 2^P as 510 * LUM_A + LUM_B: luminance is sum * LUM_A plus
  // floor(sum * LUM_B / 510), and the second term stays below 510
  localparam int LUM_SCALE = 100 << PERCENT_FRAC_BITS;
  localparam int LUM_A     = LUM_SCALE / int'(LUM_DIVISOR);
  localparam int LUM_B     = LUM_SCALE % int'(LUM_DIVISOR);
  localparam int LPROD_W   = LUM_HALF_W + LUM_RECIP_W;

  // which channel holds the maximum; ties go red, then green, then blue
  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } maxsel_t;

  logic accept;
  assign busy   = rst;
  assign accept = start && !busy;

  // ---------------- stage 1: capture the request ----------------
  logic  s1_valid;
  chan_t s1_red, s1_green, s1_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_red   <= red;
    s1_green <= green;
    s1_blue  <= blue;
  end

  // ---------------- stage 2: extremes, spread and sum ----------------
  maxsel_t             sel_next;
  chan_t               max_next, min_rg, min_next;
  logic                s2_valid;
  chan_t               s2_red, s2_green, s2_blue, s2_delta;
  logic [SUM_W-1:0]    s2_sum;
  maxsel_t             s2_sel;

  always_comb begin
    if (s1_red >= s1_green && s1_red >= s1_blue) begin
      sel_next = SEL_RED;
      max_next = s1_red;
    end else if (s1_green >= s1_blue) begin
      sel_next = SEL_GREEN;
      max_next = s1_green;
    end else begin
      sel_next = SEL_BLUE;
      max_next = s1_blue;
    end
    min_rg   = (s1_red < s1_green) ? s1_red : s1_green;
    min_next = (min_rg < s1_blue) ? min_rg : s1_blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_red   <= s1_red;
    s2_green <= s1_green;
    s2_blue  <= s1_blue;
    s2_sel   <= sel_next;
    s2_delta <= max_next - min_next;
    s2_sum   <= SUM_W'(max_next) + SUM_W'(min_next);
  end

  // ---------------- stage 3: numerators and divisors ----------------
  logic [ARITH_W-1:0]   r_w, g_w, b_w, d_w, hnum_w;
  logic [SUM_W-1:0]     sden_next;
  logic [2*SUM_W-1:0]   lum_prod_next;
  logic                 s3_valid, s3_grey;
  logic [RW-1:0]        s3_hue_num, s3_sat_num;
  logic [SUM_W-1:0]     s3_hue_den, s3_sat_den;
  logic [QW-1:0]        s3_lum_base;
  logic [LUM_HALF_W-1:0] s3_lum_half;

  always_comb begin
    r_w = ARITH_W'(s2_red);
    g_w = ARITH_W'(s2_green);
    b_w = ARITH_W'(s2_blue);
    d_w = ARITH_W'(s2_delta);
    // each arm is nonnegative and below 2^17; wrap in the wider width is harmless
    unique case (s2_sel)
      SEL_RED:   hnum_w = (s2_green >= s2_blue) ?
                          ARITH_W'(60) * (g_w - b_w) :
                          ARITH_W'(360) * d_w - ARITH_W'(60) * (b_w - g_w);
      SEL_GREEN: hnum_w = ARITH_W'(120) * d_w + ARITH_W'(60) * b_w - ARITH_W'(60) * r_w;
      SEL_BLUE:  hnum_w = ARITH_W'(240) * d_w + ARITH_W'(60) * r_w - ARITH_W'(60) * g_w;
      default:   hnum_w = '0;
    endcase
    // fold the saturation divisor above mid-grey
    sden_next = (s2_sum <= SUM_HALF) ? s2_sum : (SUM_FULL - s2_sum);
    // remainder product for luminance, below 510 * 510
    lum_prod_next = (2*SUM_W)'(s2_sum) * (2*SUM_W)'(LUM_B);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_grey     <= (s2_delta == '0);
    s3_hue_num  <= RW'(hnum_w[HNUM_W-1:0]) << HUE_FRAC_BITS;
    s3_sat_num  <= RW'(SNUM_W'(s2_delta) * SNUM_W'(100)) << PERCENT_FRAC_BITS;
    s3_hue_den  <= SUM_W'(s2_delta);
    s3_sat_den  <= sden_next;
    s3_lum_base <= QW'(s2_sum) * QW'(LUM_A);
    // halve first: floor(z / 510) is floor(floor(z / 2) / 255)
    s3_lum_half <= lum_prod_next[2*SUM_W-1:1];
  end

  // ---------------- divider lanes, QW stages ----------------
  logic [QW-1:0] hue_q, sat_q, lum_q;

  rgbhsl_div #(.RW(RW), .DW(SUM_W), .QW(QW)) u_hue_div (
    .clk (clk),
    .num (s3_hue_num),
    .den (s3_hue_den),
    .quo (hue_q)
  );

  rgbhsl_div #(.RW(RW), .DW(SUM_W), .QW(QW)) u_sat_div (
    .clk (clk),
    .num (s3_sat_num),
    .den (s3_sat_den),
    .quo (sat_q)
  );

  // luminance: reciprocal multiply for the /255, then hold for the divider depth
  logic [LPROD_W-1:0] lum_frac_prod;
  logic [QW-1:0]      lum_frac;
  logic [QW-1:0]      lum_pipe [QW];

  always_comb begin
    lum_frac_prod = LPROD_W'(s3_lum_half) * LPROD_W'(LUM_RECIP);
    lum_frac      = QW'(lum_frac_prod >> LUM_SHIFT);
  end

  always_ff @(posedge clk) begin
    lum_pipe[0] <= s3_lum_base + lum_frac;
    for (int k = 1; k < QW; k++) begin
      lum_pipe[k] <= lum_pipe[k-1];
    end
  end

  assign lum_q = lum_pipe[QW-1];

  // valid and grey flags advance alongside the divider stages
  logic [QW-1:0] vdly, gdly;

  always_ff @(posedge clk) begin
    if (rst) begin
      vdly <= '0;
    end else begin
      vdly <= {vdly[QW-2:0], s3_valid};
    end
    gdly <= {gdly[QW-2:0], s3_grey};
  end

  // ---------------- output register ----------------
  logic [QW+FIELD_W-1:0] hue_ext, sat_ext, lum_ext;

  always_comb begin
    hue_ext = {{FIELD_W{1'b0}}, hue_q};
    sat_ext = {{FIELD_W{1'b0}}, sat_q};
    lum_ext = {{FIELD_W{1'b0}}, lum_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vdly[QW-1];
    end
    // drop the divider output for grey pixels: the hue divisor is zero there
    hue        <= gdly[QW-1] ? '0 : hue_ext[FIELD_W-1:0];
    saturation <= gdly[QW-1] ? '0 : sat_ext[FIELD_W-1:0];
    luminance  <= lum_ext[FIELD_W-1:0];
  end

  // ---------------- assertions ----------------
  a_req_gives_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("request did not produce a result after the pipeline latency");

  a_done_has_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result strobe without a matching request");

  a_grey_zero: assert property (@(posedge clk) disable iff (rst)
    (accept && red == green && green == blue) |-> ##LAT (hue == '0 && saturation == '0))
    else $error("grey pixel gave nonzero hue or saturation");

  a_grey_flag: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_delta == '0) |=> (s3_valid && s3_grey))
    else $error("grey flag lost between extreme and numerator stages");

endmodule
